FILE: sv/plsm_pkg.sv
// Shared types, widths and constants for the line steer mixer.
package plsm_pkg;

  localparam int SAMPLE_W   = 7;
  localparam int POWER_W    = 8;
  localparam int LIMIT_W    = 7;
  localparam int GAIN_W     = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int ERR_W      = 9;
  localparam int ERR_SUM_W  = ERR_W + 1;
  localparam int INTEG_W    = 32;
  localparam int MUL_A_W    = GAIN_W + 1;
  localparam int MUL_B_W    = INTEG_W + 1;
  localparam int PROD_W     = MUL_A_W + MUL_B_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int FRAC_W     = 24;
  localparam int PD_SHIFT   = 16;
  localparam int WHOLE_W    = ACC_W - FRAC_W + 1;

  localparam int TURN_LIMIT_DEF = 100;
  localparam int MIX_SCALE      = 100;
  // x/100 == (x*5243)>>19 for 0 <= x < 43690
  localparam int DIV100_RECIP   = 5243;
  localparam int DIV100_SHIFT   = 19;
  // x/10 == (x*205)>>11 for 0 <= x < 1024
  localparam int DIV10_RECIP    = 205;
  localparam int DIV10_SHIFT    = 11;

  localparam logic [SAMPLE_W-1:0]       TARGET_RST    = 7'd0;
  localparam logic [GAIN_W-1:0]         GAIN_PROP_RST = 16'd384;
  localparam logic [GAIN_W-1:0]         GAIN_INTG_RST = 16'd839;
  localparam logic [GAIN_W-1:0]         GAIN_DERV_RST = 16'd5120;
  localparam logic [LIMIT_W-1:0]        CURB_HI_RST   = 7'd100;
  localparam logic signed [POWER_W-1:0] CURB_LO_RST   = -8'sd100;
  localparam logic [LIMIT_W-1:0]        PWR_MAX_RST   = 7'd100;
  localparam logic signed [POWER_W-1:0] PWR_MIN_RST   = -8'sd100;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TARGET_LEVEL,
    REG_GAIN_PROP,
    REG_GAIN_INTEG,
    REG_GAIN_DERIV,
    REG_CURB_HI,
    REG_CURB_LO,
    REG_PWR_HI,
    REG_PWR_LO
  } cfg_reg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0]       target_level;
    logic [GAIN_W-1:0]         gain_prop;
    logic [GAIN_W-1:0]         gain_integ;
    logic [GAIN_W-1:0]         gain_deriv;
    logic [LIMIT_W-1:0]        curb_hi;
    logic signed [POWER_W-1:0] curb_lo;
    logic [LIMIT_W-1:0]        pwr_hi;
    logic signed [POWER_W-1:0] pwr_lo;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_MUL_P,
    ST_MUL_I,
    ST_MUL_D,
    ST_ACC,
    ST_CURB,
    ST_STEER,
    ST_MIX,
    ST_DIV,
    ST_FIN
  } state_t;

  typedef enum logic [2:0] {
    MUL_P,
    MUL_I,
    MUL_D,
    MUL_MIX,
    MUL_DIV
  } mul_sel_t;

  typedef enum logic [1:0] {
    ACC_HOLD,
    ACC_CLR,
    ACC_ADD,
    ACC_ADD_SH
  } acc_op_t;

  typedef struct packed {
    logic     load_in;
    logic     prep;
    logic     mul_en;
    mul_sel_t mul_sel;
    acc_op_t  acc_op;
    logic     curb_load;
    logic     steer_load;
    logic     out_load;
  } cmd_t;

endpackage

FILE: sv/plsm_if.sv
// Request channel interfaces: input items, result items, register writes.
interface plsm_in_if;
  import plsm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic [SAMPLE_W-1:0]        reflect_sample;
  logic signed [POWER_W-1:0]  drive_power;
  logic                       trace_left;
  modport source (output valid, reflect_sample, drive_power, trace_left, input ready);
  modport sink   (input valid, reflect_sample, drive_power, trace_left, output ready);
endinterface

interface plsm_out_if;
  import plsm_pkg::*;
  logic                       valid;
  logic                       ready;
  logic signed [POWER_W-1:0]  left_wheel;
  logic signed [POWER_W-1:0]  right_wheel;
  logic signed [POWER_W-1:0]  turn_amount;
  modport source (output valid, left_wheel, right_wheel, turn_amount, input ready);
  modport sink   (input valid, left_wheel, right_wheel, turn_amount, output ready);
endinterface

interface plsm_cfg_if;
  import plsm_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_IDX_W-1:0]   index;
  logic [CFG_DATA_W-1:0]  data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

FILE: sv/plsm_cfg.sv
// Configuration register file.
module plsm_cfg (
  input  logic           clk,
  input  logic           rst_n,
  plsm_cfg_if.sink       cfg_if,
  output plsm_pkg::cfg_t cfg
);
  import plsm_pkg::*;

  cfg_t cfg_r, cfg_nxt;

  assign cfg_if.ready = 1'b1;
  assign cfg = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_if.valid) begin
      case (cfg_reg_t'(cfg_if.index))
        REG_TARGET_LEVEL: cfg_nxt.target_level = cfg_if.data[SAMPLE_W-1:0];
        REG_GAIN_PROP:    cfg_nxt.gain_prop    = cfg_if.data[GAIN_W-1:0];
        REG_GAIN_INTEG:   cfg_nxt.gain_integ   = cfg_if.data[GAIN_W-1:0];
        REG_GAIN_DERIV:   cfg_nxt.gain_deriv   = cfg_if.data[GAIN_W-1:0];
        REG_CURB_HI:      cfg_nxt.curb_hi      = cfg_if.data[LIMIT_W-1:0];
        REG_CURB_LO:      cfg_nxt.curb_lo      = $signed(cfg_if.data[POWER_W-1:0]);
        REG_PWR_HI:       cfg_nxt.pwr_hi       = cfg_if.data[LIMIT_W-1:0];
        REG_PWR_LO:       cfg_nxt.pwr_lo       = $signed(cfg_if.data[POWER_W-1:0]);
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target_level <= TARGET_RST;
      cfg_r.gain_prop    <= GAIN_PROP_RST;
      cfg_r.gain_integ   <= GAIN_INTG_RST;
      cfg_r.gain_deriv   <= GAIN_DERV_RST;
      cfg_r.curb_hi      <= CURB_HI_RST;
      cfg_r.curb_lo      <= CURB_LO_RST;
      cfg_r.pwr_hi       <= PWR_MAX_RST;
      cfg_r.pwr_lo       <= PWR_MIN_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

FILE: sv/plsm_ctrl.sv
// Sequencer: steps one request through the shared multiplier and the output register.
module plsm_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output plsm_pkg::cmd_t cmd
);
  import plsm_pkg::*;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign out_free  = !out_valid_r || out_ready;
  assign in_ready  = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:  if (in_valid) state_nxt = ST_PREP;
      ST_PREP:  state_nxt = ST_MUL_P;
      ST_MUL_P: state_nxt = ST_MUL_I;
      ST_MUL_I: state_nxt = ST_MUL_D;
      ST_MUL_D: state_nxt = ST_ACC;
      ST_ACC:   state_nxt = ST_CURB;
      ST_CURB:  state_nxt = ST_STEER;
      ST_STEER: state_nxt = ST_MIX;
      ST_MIX:   state_nxt = ST_DIV;
      ST_DIV:   state_nxt = ST_FIN;
      ST_FIN:   if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '{load_in: 1'b0, prep: 1'b0, mul_en: 1'b0, mul_sel: MUL_P, acc_op: ACC_HOLD,
            curb_load: 1'b0, steer_load: 1'b0, out_load: 1'b0};
    case (state_r)
      ST_IDLE:  cmd.load_in = in_valid;
      ST_PREP:  cmd.prep = 1'b1;
      ST_MUL_P: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_P;
        cmd.acc_op  = ACC_CLR;
      end
      ST_MUL_I: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_I;
        cmd.acc_op  = ACC_ADD_SH;
      end
      ST_MUL_D: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_D;
        cmd.acc_op  = ACC_ADD;
      end
      ST_ACC:   cmd.acc_op = ACC_ADD_SH;
      ST_CURB:  cmd.curb_load = 1'b1;
      ST_STEER: cmd.steer_load = 1'b1;
      ST_MIX: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_MIX;
      end
      ST_DIV: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_sel = MUL_DIV;
      end
      ST_FIN:   cmd.out_load = out_free;
      default:  cmd.load_in = 1'b0;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load)   out_valid_nxt = 1'b1;
    else if (out_ready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

FILE: sv/plsm_dp.sv
// Datapath: error, integral, shared multiplier, accumulator, clamps and wheel mix.
module plsm_dp #(
  parameter int TURN_LIMIT = plsm_pkg::TURN_LIMIT_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  plsm_pkg::cmd_t                      cmd,
  input  plsm_pkg::cfg_t                      cfg,
  input  logic [plsm_pkg::SAMPLE_W-1:0]       in_sample,
  input  logic signed [plsm_pkg::POWER_W-1:0] in_power,
  input  logic                                in_left,
  output logic signed [plsm_pkg::POWER_W-1:0] left_wheel,
  output logic signed [plsm_pkg::POWER_W-1:0] right_wheel,
  output logic signed [plsm_pkg::POWER_W-1:0] turn_amount
);
  import plsm_pkg::*;

  localparam logic signed [POWER_W:0] TL = (POWER_W+1)'(TURN_LIMIT);

  // captured request
  logic [SAMPLE_W-1:0]       sample_r;
  logic signed [POWER_W-1:0] pin_r;
  logic                      left_r;

  // controller state
  logic signed [ERR_W-1:0]     prev_err_r, err_r;
  logic signed [ERR_SUM_W-1:0] diff_r;
  logic signed [INTEG_W-1:0]   integ_r;

  // shared multiplier and accumulator
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r, prod_nxt;
  logic signed [ACC_W-1:0]   acc_r, acc_nxt;
  logic                      mix_neg_r;

  // steering
  logic signed [POWER_W-1:0] curb_r, power_r, turn_r, floor_r;
  logic [POWER_W-1:0]        m_r;

  logic signed [POWER_W-1:0] lp_r, rp_r;

  // ---- error and trapezoid integral
  logic signed [ERR_W-1:0]     e_c;
  logic signed [ERR_SUM_W-1:0] esum_c, ediff_c;
  logic signed [INTEG_W:0]     isum_c;
  logic signed [INTEG_W-1:0]   isat_c;

  always_comb begin
    e_c     = $signed({2'b00, cfg.target_level}) - $signed({2'b00, sample_r});
    esum_c  = ERR_SUM_W'(e_c) + ERR_SUM_W'(prev_err_r);
    ediff_c = ERR_SUM_W'(e_c) - ERR_SUM_W'(prev_err_r);
    isum_c  = (INTEG_W+1)'(integ_r) + (INTEG_W+1)'(esum_c);
    if (isum_c[INTEG_W] != isum_c[INTEG_W-1])
      isat_c = isum_c[INTEG_W] ? {1'b1, {(INTEG_W-1){1'b0}}} : {1'b0, {(INTEG_W-1){1'b1}}};
    else
      isat_c = isum_c[INTEG_W-1:0];
  end

  // ---- multiplier operands
  logic [15:0] mix_abs_c;

  always_comb begin
    mix_abs_c = prod_r[PROD_W-1] ? 16'(-prod_r) : prod_r[15:0];
    case (cmd.mul_sel)
      MUL_P: begin
        mul_a = $signed({1'b0, cfg.gain_prop});
        mul_b = MUL_B_W'(err_r);
      end
      MUL_I: begin
        mul_a = $signed({1'b0, cfg.gain_integ});
        mul_b = MUL_B_W'(integ_r);
      end
      MUL_D: begin
        mul_a = $signed({1'b0, cfg.gain_deriv});
        mul_b = MUL_B_W'(diff_r);
      end
      MUL_MIX: begin
        mul_a = $signed({{(MUL_A_W-POWER_W){1'b0}}, m_r});
        mul_b = MUL_B_W'(power_r);
      end
      MUL_DIV: begin
        mul_a = MUL_A_W'(DIV100_RECIP);
        mul_b = $signed({{(MUL_B_W-16){1'b0}}, mix_abs_c});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
    prod_nxt = mul_a * mul_b;
  end

  // ---- accumulator, Q.24
  always_comb begin
    case (cmd.acc_op)
      ACC_CLR:    acc_nxt = '0;
      ACC_ADD:    acc_nxt = acc_r + ACC_W'(prod_r);
      ACC_ADD_SH: acc_nxt = acc_r + {prod_r[ACC_W-PD_SHIFT-1:0], {PD_SHIFT{1'b0}}};
      default:    acc_nxt = acc_r;
    endcase
  end

  // ---- truncate toward zero, curb clamp, power clamp
  logic signed [ACC_W-1:0]   acc_neg_c;
  logic [WHOLE_W-2:0]        mag_c;
  logic signed [WHOLE_W-1:0] whole_c, cmax_c, cmin_c;
  logic signed [POWER_W-1:0] curb_c, pmax_c, pclamp_c;

  always_comb begin
    acc_neg_c = -acc_r;
    mag_c     = acc_r[ACC_W-1] ? acc_neg_c[ACC_W-1:FRAC_W] : acc_r[ACC_W-1:FRAC_W];
    whole_c   = acc_r[ACC_W-1] ? -$signed({1'b0, mag_c}) : $signed({1'b0, mag_c});
    cmax_c    = $signed({{(WHOLE_W-LIMIT_W){1'b0}}, cfg.curb_hi});
    cmin_c    = WHOLE_W'(cfg.curb_lo);
    if (whole_c > cmax_c)      curb_c = $signed({1'b0, cfg.curb_hi});
    else if (whole_c < cmin_c) curb_c = cfg.curb_lo;
    else                       curb_c = whole_c[POWER_W-1:0];

    pmax_c = $signed({1'b0, cfg.pwr_hi});
    if (pin_r > pmax_c)           pclamp_c = pmax_c;
    else if (pin_r < cfg.pwr_lo)  pclamp_c = cfg.pwr_lo;
    else                          pclamp_c = pin_r;
  end

  // ---- side sign, turn limit, mix factor, power/10 floor
  function automatic logic signed [POWER_W:0] in_left_sel(
    input logic                      lft,
    input logic signed [POWER_W-1:0] c
  );
    logic signed [POWER_W:0] cw;
    cw = (POWER_W+1)'(c);
    return lft ? -cw : cw;
  endfunction

  logic signed [POWER_W:0]   t_c, tclamp_c, tabs_c, pabs_c;
  logic [POWER_W+8:0]        fprod_c;
  logic [POWER_W-1:0]        fq_c;

  always_comb begin
    t_c = in_left_sel(left_r, curb_r);
    if (t_c > TL)       tclamp_c = TL;
    else if (t_c < -TL) tclamp_c = -TL;
    else                tclamp_c = t_c;
    tabs_c  = tclamp_c[POWER_W] ? -tclamp_c : tclamp_c;
    pabs_c  = power_r[POWER_W-1] ? -(POWER_W+1)'(power_r) : (POWER_W+1)'(power_r);
    fprod_c = (POWER_W+9)'(pabs_c) * (POWER_W+9)'(DIV10_RECIP);
    fq_c    = POWER_W'(fprod_c >> DIV10_SHIFT);
  end

  // ---- quotient, floor and wheel assignment
  logic [POWER_W-1:0]        q_c;
  logic signed [POWER_W-1:0] qs_c, inner_c, lp_c, rp_c;

  always_comb begin
    q_c     = prod_r[DIV100_SHIFT+POWER_W-1:DIV100_SHIFT];
    qs_c    = mix_neg_r ? -$signed(q_c) : $signed(q_c);
    inner_c = (qs_c < floor_r) ? floor_r : qs_c;
    if (turn_r > 0) begin
      lp_c = power_r;
      rp_c = inner_c;
    end else if (turn_r < 0) begin
      lp_c = inner_c;
      rp_c = power_r;
    end else begin
      lp_c = power_r;
      rp_c = power_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_err_r <= '0;
      integ_r    <= '0;
    end else if (cmd.prep) begin
      prev_err_r <= e_c;
      integ_r    <= isat_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sample_r <= in_sample;
      pin_r    <= in_power;
      left_r   <= in_left;
    end
    if (cmd.prep) begin
      err_r  <= e_c;
      diff_r <= ediff_c;
    end
    if (cmd.mul_en) prod_r <= prod_nxt;
    if (cmd.mul_en && cmd.mul_sel == MUL_DIV) mix_neg_r <= prod_r[PROD_W-1];
    acc_r <= acc_nxt;
    if (cmd.curb_load) begin
      curb_r  <= curb_c;
      power_r <= pclamp_c;
    end
    if (cmd.steer_load) begin
      turn_r  <= tclamp_c[POWER_W-1:0];
      m_r     <= POWER_W'(MIX_SCALE) - tabs_c[POWER_W-1:0];
      floor_r <= power_r[POWER_W-1] ? -$signed(fq_c) : $signed(fq_c);
    end
    if (cmd.out_load) begin
      lp_r        <= lp_c;
      rp_r        <= rp_c;
      turn_amount <= turn_r;
    end
  end

  assign left_wheel  = lp_r;
  assign right_wheel = rp_r;

endmodule

FILE: sv/pid_line_steer_mixer.sv
// Top level: PID line-edge steering with a differential-drive wheel mixer.
//
// Usage
//   in_if  : one request per control tick (reflect_sample, drive_power,
//            trace_left), accepted when valid and ready are both high.
//   out_if : one result request per input (left_wheel, right_wheel,
//            turn_amount), held in an output register until taken.
//   cfg_if : register writes (index, data), always ready; write only while
//            no request is in flight.
// Sequence
//   The sequencer walks each request through PREP, MUL_P, MUL_I, MUL_D,
//   ACC, CURB, STEER, MIX, DIV and FIN, passing five products (P, I, D,
//   mix, /100) through the single 17x33 multiplier, with clamp stages in
//   between; a new request is accepted only when the sequencer is idle.
// Stall
//   While a result waits on out_if, the next request is accepted and worked
//   on; it parks in the final step until the output register is free.
// Reset
//   rst_n (synchronous, active low) restores register defaults and clears
//   the previous error, the integral sum and the output valid.
module pid_line_steer_mixer #(
  parameter int TURN_LIMIT = plsm_pkg::TURN_LIMIT_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  plsm_in_if.sink     in_if,
  plsm_out_if.source  out_if,
  plsm_cfg_if.sink    cfg_if
);
  import plsm_pkg::*;

  cfg_t cfg;
  cmd_t cmd;

  // register file
  plsm_cfg u_cfg (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_if (cfg_if),
    .cfg    (cfg)
  );

  // sequencer owns the input and output handshakes
  plsm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  // arithmetic and result register
  plsm_dp #(.TURN_LIMIT(TURN_LIMIT)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .cfg         (cfg),
    .in_sample   (in_if.reflect_sample),
    .in_power    (in_if.drive_power),
    .in_left     (in_if.trace_left),
    .left_wheel  (out_if.left_wheel),
    .right_wheel (out_if.right_wheel),
    .turn_amount (out_if.turn_amount)
  );

endmodule

FILE: sv/plsm_checker.sv
// Port-level checks for the steer mixer, bound to the top level.
module plsm_checker #(
  parameter int TURN_LIMIT = plsm_pkg::TURN_LIMIT_DEF
) (
  input logic                                clk,
  input logic                                rst_n,
  input logic                                in_valid,
  input logic                                in_ready,
  input logic                                out_valid,
  input logic signed [plsm_pkg::POWER_W-1:0] left_wheel,
  input logic signed [plsm_pkg::POWER_W-1:0] right_wheel,
  input logic signed [plsm_pkg::POWER_W-1:0] turn_amount
);
  import plsm_pkg::*;

  localparam logic signed [POWER_W-1:0] TL = POWER_W'(TURN_LIMIT);

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while one is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a request in work");

  a_turn_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (turn_amount <= TL) && (turn_amount >= -TL))
    else $error("turn beyond limit");

  a_straight_equal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (turn_amount == '0) |-> left_wheel == right_wheel)
    else $error("wheels differ with zero turn");

endmodule

bind pid_line_steer_mixer plsm_checker #(.TURN_LIMIT(TURN_LIMIT)) u_plsm_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_if.valid),
  .in_ready    (in_if.ready),
  .out_valid   (out_if.valid),
  .left_wheel  (out_if.left_wheel),
  .right_wheel (out_if.right_wheel),
  .turn_amount (out_if.turn_amount)
);
